### rtl/core/assert_macros.svh
// assertion helpers for the line editor checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked out of reset only
`define CLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/cle_pkg.sv
package cle_pkg;

  typedef enum logic [1:0] {
    MODE_KEY  = 2'd0,
    MODE_READ = 2'd1,
    MODE_OUT  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    K_ECHO     = 3'd0,
    K_CHAR     = 3'd1,
    K_EOF      = 3'd2,
    K_ABORT    = 3'd3,
    K_CLEANUP  = 3'd4,
    K_CONTINUE = 3'd5,
    K_EMPTY    = 3'd6,
    K_DROP     = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    OP_PRINT    = 3'd0,
    OP_TAB      = 3'd1,
    OP_ERASE    = 3'd2,
    OP_CR       = 3'd3,
    OP_FLUSH    = 3'd4,
    OP_READ     = 3'd5,
    OP_OUT_NL   = 3'd6,
    OP_OUT_CHAR = 3'd7
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    kind_t      evt;
  } cmd_t;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_EOF  = 8'h1A;
  localparam logic [7:0] CH_INTR = 8'h03;
  localparam logic [7:0] CH_BEL  = 8'h07;
  localparam logic [7:0] CH_DLE  = 8'h10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] TAB_STOP   = 4'd8;
  localparam logic [3:0] ERASE_MAX  = 4'd8;

endpackage

### rtl/core/cle_ram.sv
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/cle_front.sv
module cle_front import cle_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_data,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  mode_t mode;

  assign mode     = mode_t'(in_mode);
  assign in_ready = !q_full;
  // mode 3 is taken and dropped here
  assign push     = in_valid && !q_full && (mode != MODE_NONE);

  always_comb begin
    push_cmd.op   = OP_FLUSH;
    push_cmd.data = in_data;
    push_cmd.evt  = K_CHAR;
    unique case (mode)
      MODE_KEY: begin
        if (in_data == CH_CR) begin
          push_cmd.op = OP_CR;
        end else if (in_data == CH_BS || in_data == CH_DEL) begin
          push_cmd.op = OP_ERASE;
        end else if (in_data == CH_TAB) begin
          push_cmd.op = OP_TAB;
        end else if (in_data >= CH_SP && in_data < CH_DEL) begin
          push_cmd.op = OP_PRINT;
        end else begin
          push_cmd.op = OP_FLUSH;
          unique case (in_data)
            CH_EOF:  push_cmd.evt = K_EOF;
            CH_INTR: push_cmd.evt = K_ABORT;
            CH_BEL:  push_cmd.evt = K_CLEANUP;
            CH_DLE:  push_cmd.evt = K_CONTINUE;
            default: push_cmd.evt = K_CHAR;
          endcase
        end
      end
      MODE_READ: push_cmd.op = OP_READ;
      MODE_OUT: begin
        if (in_data == CH_LF) begin
          push_cmd.op = OP_OUT_NL;
        end else begin
          push_cmd.op = OP_OUT_CHAR;
        end
      end
      default: push_cmd.op = OP_FLUSH;
    endcase
  end

endmodule

### rtl/core/cle_queue.sv
module cle_queue import cle_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + (QPTR_W+1)'(1);
      2'b01:   count_nxt = count_r - (QPTR_W+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/cle_back.sv
module cle_back import cle_pkg::*; #(
  parameter int LINE_DEPTH  = 64,
  parameter int COLUMN_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output kind_t      out_kind,
  output logic [7:0] out_value,
  output logic       out_last
);

  localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int COL_W = COLUMN_BITS;
  localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};
  localparam logic [1:0] PH_LAST = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SPACES   = 7'b0000010,
    S_LF       = 7'b0000100,
    S_EVENT    = 7'b0001000,
    S_ERASE_RD = 7'b0010000,
    S_ERASE    = 7'b0100000,
    S_READ_RD  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] typed_r, typed_nxt;
  logic [CNT_W-1:0] read_r, read_nxt;
  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [2:0]       tab_left_r, tab_left_nxt;
  logic [COL_W-1:0] erase_start_r, erase_start_nxt;
  logic [3:0]       erase_left_r, erase_left_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             tail_evt_r, tail_evt_nxt;
  kind_t            tail_kind_r, tail_kind_nxt;
  logic [7:0]       tail_value_r, tail_value_nxt;

  logic             out_valid_r;
  kind_t            out_kind_r;
  logic [7:0]       out_value_r;
  logic             out_last_r;

  logic             emit_ok, emit, e_last;
  kind_t            e_kind;
  logic [7:0]       e_value;
  logic             is_key;
  logic [3:0]       spaces;
  logic [CNT_W-1:0] typed_dec;
  logic [COL_W-1:0] col_dec;
  logic [3:0]       erase_left_dec;
  logic             erase_more;

  logic             line_we, col_we;
  logic [7:0]       line_wdata;
  logic [7:0]       line_rdata;
  logic [COL_W-1:0] col_rdata;

  function automatic logic [COL_W-1:0] sat_add(input logic [COL_W-1:0] c,
                                               input logic [3:0] inc);
    logic [COL_W:0] sum;
    sum = {1'b0, c} + (COL_W+1)'(inc);
    return sum[COL_W] ? COL_MAX : sum[COL_W-1:0];
  endfunction

  cle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk     (clk),
    .wr_en   (line_we),
    .wr_addr (typed_r[IDX_W-1:0]),
    .wr_data (line_wdata),
    .rd_addr (read_r[IDX_W-1:0]),
    .rd_data (line_rdata)
  );

  cle_ram #(.WIDTH(COL_W), .DEPTH(LINE_DEPTH)) u_col_ram (
    .clk     (clk),
    .wr_en   (col_we),
    .wr_addr (typed_r[IDX_W-1:0]),
    .wr_data (col_r),
    .rd_addr (typed_dec[IDX_W-1:0]),
    .rd_data (col_rdata)
  );

  assign emit_ok        = !out_valid_r || out_ready;
  assign typed_dec      = typed_r - CNT_W'(1);
  assign spaces         = TAB_STOP - {1'b0, col_r[2:0]};
  assign col_dec        = col_r - COL_W'(1);
  assign erase_left_dec = erase_left_r - 4'd1;
  assign erase_more     = (col_dec > erase_start_r) && (erase_left_dec != 4'd0);
  assign is_key         = (q_cmd.op == OP_PRINT) || (q_cmd.op == OP_TAB) ||
                          (q_cmd.op == OP_ERASE) || (q_cmd.op == OP_CR) ||
                          (q_cmd.op == OP_FLUSH);

  always_comb begin
    state_nxt       = state_r;
    typed_nxt       = typed_r;
    read_nxt        = read_r;
    pend_nxt        = pend_r;
    col_nxt         = col_r;
    tab_left_nxt    = tab_left_r;
    erase_start_nxt = erase_start_r;
    erase_left_nxt  = erase_left_r;
    phase_nxt       = phase_r;
    tail_evt_nxt    = tail_evt_r;
    tail_kind_nxt   = tail_kind_r;
    tail_value_nxt  = tail_value_r;
    pop             = 1'b0;
    emit            = 1'b0;
    e_kind          = K_ECHO;
    e_value         = 8'h00;
    e_last          = 1'b0;
    line_we         = 1'b0;
    col_we          = 1'b0;
    line_wdata      = q_cmd.data;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && emit_ok) begin
          pop = 1'b1;
          if (is_key && pend_r != '0) begin
            emit    = 1'b1;
            e_kind  = K_DROP;
            e_value = q_cmd.data;
            e_last  = 1'b1;
          end else begin
            unique case (q_cmd.op) inside
              OP_PRINT, OP_TAB: begin
                if (typed_r >= CNT_W'(LINE_DEPTH - 1)) begin
                  emit    = 1'b1;
                  e_kind  = K_DROP;
                  e_value = q_cmd.data;
                  e_last  = 1'b1;
                end else begin
                  line_we   = 1'b1;
                  col_we    = 1'b1;
                  typed_nxt = typed_r + CNT_W'(1);
                  emit      = 1'b1;
                  if (q_cmd.op == OP_PRINT) begin
                    e_value = q_cmd.data;
                    e_last  = 1'b1;
                    col_nxt = sat_add(col_r, 4'd1);
                  end else begin
                    e_value      = CH_SP;
                    e_last       = (spaces == 4'd1);
                    tab_left_nxt = 3'(spaces - 4'd1);
                    col_nxt      = sat_add(col_r, spaces);
                    if (spaces != 4'd1) begin
                      state_nxt = S_SPACES;
                    end
                  end
                end
              end
              OP_ERASE: begin
                if (typed_r != '0) begin
                  typed_nxt = typed_dec;
                  state_nxt = S_ERASE_RD;
                end
              end
              OP_CR: begin
                line_we      = 1'b1;
                line_wdata   = CH_LF;
                emit         = 1'b1;
                e_value      = CH_CR;
                tail_evt_nxt = 1'b0;
                col_nxt      = '0;
                pend_nxt     = typed_r + CNT_W'(1);
                read_nxt     = '0;
                typed_nxt    = '0;
                state_nxt    = S_LF;
              end
              OP_FLUSH: begin
                emit           = 1'b1;
                e_value        = CH_CR;
                tail_evt_nxt   = 1'b1;
                tail_kind_nxt  = q_cmd.evt;
                tail_value_nxt = (q_cmd.evt == K_CHAR) ? q_cmd.data : 8'h00;
                col_nxt        = '0;
                pend_nxt       = '0;
                read_nxt       = '0;
                typed_nxt      = '0;
                state_nxt      = S_LF;
              end
              OP_READ: begin
                if (pend_r != '0 && read_r < CNT_W'(LINE_DEPTH)) begin
                  state_nxt = S_READ_RD;
                end else begin
                  emit   = 1'b1;
                  e_kind = K_EMPTY;
                  e_last = 1'b1;
                end
              end
              OP_OUT_NL: begin
                emit         = 1'b1;
                e_value      = CH_CR;
                tail_evt_nxt = 1'b0;
                col_nxt      = '0;
                state_nxt    = S_LF;
              end
              OP_OUT_CHAR: begin
                emit    = 1'b1;
                e_value = q_cmd.data;
                e_last  = 1'b1;
                col_nxt = sat_add(col_r, 4'd1);
              end
              default: state_nxt = S_IDLE;
            endcase
          end
        end
      end
      S_SPACES: begin
        if (emit_ok) begin
          emit         = 1'b1;
          e_value      = CH_SP;
          e_last       = (tab_left_r == 3'd1);
          tab_left_nxt = tab_left_r - 3'd1;
          if (tab_left_r == 3'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LF: begin
        if (emit_ok) begin
          emit      = 1'b1;
          e_value   = CH_LF;
          e_last    = !tail_evt_r;
          state_nxt = tail_evt_r ? S_EVENT : S_IDLE;
        end
      end
      S_EVENT: begin
        if (emit_ok) begin
          emit      = 1'b1;
          e_kind    = tail_kind_r;
          e_value   = tail_value_r;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ERASE_RD: begin
        if (col_r > col_rdata) begin
          erase_start_nxt = col_rdata;
          erase_left_nxt  = ERASE_MAX;
          phase_nxt       = 2'd0;
          state_nxt       = S_ERASE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ERASE: begin
        if (emit_ok) begin
          emit    = 1'b1;
          e_value = (phase_r == 2'd1) ? CH_SP : CH_BS;
          if (phase_r != PH_LAST) begin
            phase_nxt = phase_r + 2'd1;
          end else begin
            phase_nxt      = 2'd0;
            e_last         = !erase_more;
            col_nxt        = col_dec;
            erase_left_nxt = erase_left_dec;
            if (!erase_more) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_READ_RD: begin
        if (emit_ok) begin
          emit      = 1'b1;
          e_kind    = K_CHAR;
          e_value   = line_rdata;
          e_last    = 1'b1;
          read_nxt  = read_r + CNT_W'(1);
          pend_nxt  = pend_r - CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      typed_r     <= '0;
      read_r      <= '0;
      pend_r      <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      typed_r <= typed_nxt;
      read_r  <= read_nxt;
      pend_r  <= pend_nxt;
      col_r   <= col_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tab_left_r    <= tab_left_nxt;
    erase_start_r <= erase_start_nxt;
    erase_left_r  <= erase_left_nxt;
    phase_r       <= phase_nxt;
    tail_evt_r    <= tail_evt_nxt;
    tail_kind_r   <= tail_kind_nxt;
    tail_value_r  <= tail_value_nxt;
    if (emit) begin
      out_kind_r  <= e_kind;
      out_value_r <= e_value;
      out_last_r  <= e_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

### rtl/core/console_line_editor.sv
// channel  | direction | handshake            | payload
// input    | in        | in_valid / in_ready   | in_mode, in_data
// result   | out       | out_valid / out_ready | out_kind, out_value, out_last
//
// back end: one result transfer per cycle while out_ready does not hold it
// a read and an erase that finds a character each wait for a memory read
// longest item is erasing a tab
// a two-entry command queue lets keys be taken while the editor back end works
// rst_n is synchronous; counts, cursor and queue clear, line memories do not
// out_ready low holds the back end; in_ready drops only when the queue is full
module console_line_editor import cle_pkg::*; #(
  parameter int LINE_DEPTH  = 64,
  parameter int COLUMN_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_value,
  output logic       out_last
);

  logic  q_full, push, pop, q_valid;
  cmd_t  push_cmd, q_cmd;
  kind_t kind;

  cle_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  cle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  cle_back #(
    .LINE_DEPTH  (LINE_DEPTH),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

  assign out_kind = kind;

endmodule

### rtl/core/cle_checker.sv
`include "assert_macros.svh"

module cle_checker import cle_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_value,
  input logic       out_last
);

  logic [11:0] out_word;
  logic        out_stall;
  logic        out_event;

  assign out_word  = {out_kind, out_value, out_last};
  assign out_stall = out_valid && !out_ready;
  assign out_event = (out_kind == K_EOF) || (out_kind == K_ABORT) ||
                     (out_kind == K_CLEANUP) || (out_kind == K_CONTINUE) ||
                     (out_kind == K_EMPTY);

  `CLE_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_word), "result changed while stalled")
  `CLE_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result shown after reset")
  `CLE_ASSERT(a_tail_last, out_valid && out_kind != K_ECHO |-> out_last, "non-echo result not last")
  `CLE_ASSERT(a_event_zero, out_valid && out_event |-> out_value == 8'h00, "event carries a value")

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);
